// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define NLPR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nlpr assertion failed");

`define NLPR_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("nlpr forbidden condition seen");

`endif

// ===== src/nlpr_pkg.sv =====
`default_nettype none

package nlpr_pkg;

    localparam int RAMP_ENTRIES = 16;
    localparam int PALETTE_SIZE = 256;

    localparam int SLOT_W  = 4;
    localparam int INDEX_W = 8;
    localparam int CHAN_W  = 8;
    localparam int LUM_W   = 8;
    localparam int DIFF_W  = LUM_W + 1;
    localparam int SUM_W   = 21;
    localparam int RECIP_W = 21;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 33;
    localparam int QUOT_W  = PROD_W - RECIP_SHIFT;
    localparam int SEL_W   = ($clog2(RAMP_ENTRIES + 1) > SLOT_W) ?
                             $clog2(RAMP_ENTRIES + 1) : SLOT_W;

    localparam logic [SUM_W-1:0]   WEIGHT_RED   = SUM_W'(1063);
    localparam logic [SUM_W-1:0]   WEIGHT_GREEN = SUM_W'(3576);
    localparam logic [SUM_W-1:0]   WEIGHT_BLUE  = SUM_W'(361);
    // ceil(2^33 / 5000): exact quotient for every weighted sum of 8-bit channels
    localparam logic [RECIP_W-1:0] RECIP_MULT   = RECIP_W'(1717987);

    localparam logic [INDEX_W-1:0] FIXED_BLACK   = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] FIXED_WHITE   = INDEX_W'(31);
    localparam logic [DIFF_W-1:0]  NO_MATCH_DIFF = DIFF_W'(256);
    localparam logic [LUM_W-1:0]   LUM_MAX       = LUM_W'(255);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [INDEX_W-1:0] pidx;
        logic [LUM_W-1:0]   lum;
    } front_t;

    typedef struct packed {
        logic               valid;
        logic               fixed;
        logic [LUM_W-1:0]   lum;
        logic [DIFF_W-1:0]  best;
        logic [INDEX_W-1:0] src;
        logic [INDEX_W-1:0] result;
    } token_t;

endpackage

`default_nettype wire

// ===== src/nearest_luminance_palette_remap_core.sv =====
// Nearest-luminance palette remap core.
// Input channel item_valid/item_ready carries kind, slot, palette_index and RGB.
// A load item (kind 0) stores palette_index and the brightness of its RGB in a
// ramp slot; it yields no result. A map item (kind 1) yields one result on
// result_valid/result_ready: source_index and the ramp palette index of nearest
// brightness (lowest slot on ties); indices 0 and 31 map to themselves.
// One item is in flight at a time. Brightness is computed in registered steps
// (weighted sum, then reciprocal multiply). A map token then walks the row of
// RAMP_ENTRIES slot cells, one cell per cycle, and lands in the output register.
// The output register frees item_ready as soon as the result is stored, so the
// next item enters while that result waits. A stalled result holds the token
// in the last cell and keeps item_ready low.
// Reset clears all control state; ramp slots stay undefined until loaded.
`default_nettype none

module nearest_luminance_palette_remap_core
    import nlpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic               kind,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [INDEX_W-1:0] palette_index,
    input  wire logic [CHAN_W-1:0]  red,
    input  wire logic [CHAN_W-1:0]  green,
    input  wire logic [CHAN_W-1:0]  blue,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [INDEX_W-1:0]      source_index,
    output logic [INDEX_W-1:0]      mapped_index
);

    logic                     take;
    logic                     busy_reg;
    logic                     busy_next;
    front_t                   front;
    token_t                   inject;
    token_t                   chain [0:RAMP_ENTRIES];
    logic [RAMP_ENTRIES-1:0]  wr_en;
    logic [RAMP_ENTRIES-1:0]  chain_valid;
    logic                     load_now;
    logic                     drop_now;
    logic                     map_now;
    logic                     slot_ok;
    logic                     shift_en;
    logic                     done;
    logic                     out_valid_reg;
    logic [INDEX_W-1:0]       source_reg;
    logic [INDEX_W-1:0]       mapped_reg;

    assign take = item_valid && item_ready;
    assign item_ready = !busy_reg;

    nlpr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .kind          (kind),
        .slot          (slot),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .front         (front)
    );

    assign slot_ok  = SEL_W'(front.slot) < SEL_W'(RAMP_ENTRIES);
    assign load_now = front.valid && (front.kind == KIND_LOAD);
    assign map_now  = front.valid && (front.kind == KIND_MAP)
                   && ((INDEX_W + 1)'(front.pidx) < (INDEX_W + 1)'(PALETTE_SIZE));
    assign drop_now = front.valid && !map_now;

    always_comb
    begin
        inject.valid  = map_now;
        inject.fixed  = (front.pidx == FIXED_BLACK) || (front.pidx == FIXED_WHITE);
        inject.lum    = front.lum;
        inject.best   = NO_MATCH_DIFF;
        inject.src    = front.pidx;
        inject.result = front.pidx;
    end

    assign chain[0] = inject;
    assign shift_en = !(chain[RAMP_ENTRIES].valid && out_valid_reg && !result_ready);
    assign done     = chain[RAMP_ENTRIES].valid && shift_en;

    for (genvar k = 0; k < RAMP_ENTRIES; k++)
    begin : g_cell
        assign wr_en[k] = load_now && slot_ok && (SEL_W'(front.slot) == SEL_W'(k));
        assign chain_valid[k] = chain[k + 1].valid;

        nlpr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en[k]),
            .wr_index (front.pidx),
            .wr_lum   (front.lum),
            .shift_en (shift_en),
            .tok_in   (chain[k]),
            .tok_out  (chain[k + 1])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        else if (drop_now || done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            source_reg <= chain[RAMP_ENTRIES].src;
            mapped_reg <= chain[RAMP_ENTRIES].result;
        end
    end

    assign result_valid = out_valid_reg;
    assign source_index = source_reg;
    assign mapped_index = mapped_reg;

`include "assert_macros.svh"

    `NLPR_ASSERT(a_one_token, $onehot0(chain_valid))
    `NLPR_ASSERT(a_ready_empty, item_ready |-> (chain_valid == '0) && !front.valid)
    `NLPR_ASSERT(a_result_from_chain, $rose(result_valid) |-> $past(chain[RAMP_ENTRIES].valid))
    `NLPR_ASSERT_NEVER(a_fixed_black, result_valid && (source_index == FIXED_BLACK)
        && (mapped_index != FIXED_BLACK))

endmodule

`default_nettype wire

// ===== src/nlpr_front.sv =====
`default_nettype none

module nlpr_front
    import nlpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic               kind,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [INDEX_W-1:0] palette_index,
    input  wire logic [CHAN_W-1:0]  red,
    input  wire logic [CHAN_W-1:0]  green,
    input  wire logic [CHAN_W-1:0]  blue,
    output front_t                  front
);

    logic               a_valid_reg;
    logic               a_kind_reg;
    logic [SLOT_W-1:0]  a_slot_reg;
    logic [INDEX_W-1:0] a_pidx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;

    logic               b_valid_reg;
    logic               b_kind_reg;
    logic [SLOT_W-1:0]  b_slot_reg;
    logic [INDEX_W-1:0] b_pidx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;

    logic [QUOT_W-1:0]  quot;

    assign sum_next = WEIGHT_RED * SUM_W'(red)
                    + WEIGHT_GREEN * SUM_W'(green)
                    + WEIGHT_BLUE * SUM_W'(blue);

    assign prod_next = PROD_W'(sum_reg) * PROD_W'(RECIP_MULT);

    assign quot = prod_reg[PROD_W-1:RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= take;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_kind_reg <= kind;
            a_slot_reg <= slot;
            a_pidx_reg <= palette_index;
            sum_reg    <= sum_next;
        end
        if (a_valid_reg)
        begin
            b_kind_reg <= a_kind_reg;
            b_slot_reg <= a_slot_reg;
            b_pidx_reg <= a_pidx_reg;
            prod_reg   <= prod_next;
        end
    end

    always_comb
    begin
        front.valid = b_valid_reg;
        front.kind  = b_kind_reg;
        front.slot  = b_slot_reg;
        front.pidx  = b_pidx_reg;
        front.lum   = (quot > QUOT_W'(LUM_MAX)) ? LUM_MAX : quot[LUM_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/nlpr_cell.sv =====
`default_nettype none

module nlpr_cell
    import nlpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_index,
    input  wire logic [LUM_W-1:0]   wr_lum,
    input  wire logic               shift_en,
    input  wire token_t             tok_in,
    output token_t                  tok_out
);

    logic [INDEX_W-1:0] entry_index_reg;
    logic [LUM_W-1:0]   entry_lum_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic [LUM_W-1:0]   diff;

    assign diff = (tok_in.lum >= entry_lum_reg) ? (tok_in.lum - entry_lum_reg)
                                                : (entry_lum_reg - tok_in.lum);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.fixed && (DIFF_W'(diff) < tok_in.best))
        begin
            tok_next.best   = DIFF_W'(diff);
            tok_next.result = entry_index_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_index_reg <= wr_index;
            entry_lum_reg   <= wr_lum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else if (shift_en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
